// ===== hw/rtl/mck_pkg.sv =====
// ----------------------------------------------------------------------------
// Morse keyer package
// Shared types, register indexes, reset values and the Morse code table used
// by the keyer controller, datapath and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package mck_pkg;

    // Field widths.
    localparam int CharW  = 8;
    localparam int DurW   = 10;
    localparam int CfgIdxW = 3;
    localparam int SymLenW = 3;
    localparam int MaxSyms = 5;

    // Register reset values in milliseconds.
    localparam logic [DurW-1:0] DotOnReset     = 10'd50;
    localparam logic [DurW-1:0] DashOnReset    = 10'd200;
    localparam logic [DurW-1:0] SymbolGapReset = 10'd200;
    localparam logic [DurW-1:0] LetterGapReset = 10'd200;
    localparam logic [DurW-1:0] WordGapReset   = 10'd250;

    // Character codes that bound the translated ranges.
    localparam logic [CharW-1:0] SpaceChar   = 8'h20;
    localparam logic [CharW-1:0] LowerAChar  = 8'h61;
    localparam logic [CharW-1:0] LowerZChar  = 8'h7A;
    localparam logic [CharW-1:0] DigitZero   = 8'h30;
    localparam logic [CharW-1:0] DigitNine   = 8'h39;

    // Configuration register indexes.
    typedef enum logic [CfgIdxW-1:0] {
        CFG_DOT_ON     = 3'd0,
        CFG_DASH_ON    = 3'd1,
        CFG_SYMBOL_GAP = 3'd2,
        CFG_LETTER_GAP = 3'd3,
        CFG_WORD_GAP   = 3'd4
    } cfg_idx_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WORD,
        ST_ON,
        ST_GAP,
        ST_LETTER
    } state_t;

    // Kind of interval placed in the output register.
    typedef enum logic [1:0] {
        EMIT_WORD,
        EMIT_ON,
        EMIT_GAP,
        EMIT_LETTER
    } emit_kind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       emit;
        emit_kind_t kind;
        logic       advance;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_space;
        logic in_len_zero;
        logic last_symbol;
        logic no_symbols;
        logic out_free;
    } ctrl_status_t;

    // One Morse code: number of symbols and the symbols, first in bit 0,
    // a set bit meaning a dash.
    typedef struct packed {
        logic [SymLenW-1:0] len;
        logic [MaxSyms-1:0] pattern;
    } morse_code_t;

    localparam logic [MaxSyms-1:0] LetterPat [26] = '{
        5'b00010, 5'b00001, 5'b00101, 5'b00001, 5'b00000, 5'b00100,
        5'b00011, 5'b00000, 5'b00000, 5'b01110, 5'b00101, 5'b00010,
        5'b00011, 5'b00001, 5'b00111, 5'b00110, 5'b01011, 5'b00010,
        5'b00000, 5'b00001, 5'b00100, 5'b01000, 5'b00110, 5'b01001,
        5'b01101, 5'b00011
    };

    localparam logic [SymLenW-1:0] LetterLen [26] = '{
        3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4,
        3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4,
        3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3,
        3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4,
        3'd4, 3'd4
    };

    localparam logic [MaxSyms-1:0] DigitPat [10] = '{
        5'b11111, 5'b11110, 5'b11100, 5'b11000, 5'b10000,
        5'b00000, 5'b00001, 5'b00011, 5'b00111, 5'b01111
    };

    // Looks up a character; untranslated characters give a zero length.
    function automatic morse_code_t morse_lookup(input logic [CharW-1:0] ch);
        morse_code_t       code;
        logic [CharW-1:0]  letter_off;
        logic [CharW-1:0]  digit_off;
        letter_off   = ch - LowerAChar;
        digit_off    = ch - DigitZero;
        code.len     = '0;
        code.pattern = '0;
        if (ch >= LowerAChar && ch <= LowerZChar) begin
            code.len     = LetterLen[letter_off[4:0]];
            code.pattern = LetterPat[letter_off[4:0]];
        end else if (ch >= DigitZero && ch <= DigitNine) begin
            code.len     = SymLenW'(MaxSyms);
            code.pattern = DigitPat[digit_off[3:0]];
        end
        return code;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mck_if.sv =====
// ----------------------------------------------------------------------------
// Morse keyer channel interfaces
// Valid/ready channels for characters in, timed intervals out and register
// writes.
// ----------------------------------------------------------------------------
`default_nettype none

// Character channel.
interface mck_char_if;
    logic                        valid;
    logic                        ready;
    logic [mck_pkg::CharW-1:0]   character;

    modport source (output valid, output character, input ready);
    modport sink   (input valid, input character, output ready);
endinterface

// Interval result channel.
interface mck_result_if;
    logic                        valid;
    logic                        ready;
    logic                        tone_on;
    logic [mck_pkg::DurW-1:0]    duration_ms;
    logic                        last_of_run;

    modport source (output valid, output tone_on, output duration_ms,
                    output last_of_run, input ready);
    modport sink   (input valid, input tone_on, input duration_ms,
                    input last_of_run, output ready);
endinterface

// Register write channel.
interface mck_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [mck_pkg::CfgIdxW-1:0] index;
    logic [mck_pkg::DurW-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mck_ctrl.sv =====
// ----------------------------------------------------------------------------
// Morse keyer controller
// Steps through the intervals of one character, one per cycle whenever the
// output register can take it.
// ----------------------------------------------------------------------------
`default_nettype none

module mck_ctrl
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_ready,
    input  mck_pkg::ctrl_status_t  status,
    output mck_pkg::ctrl_cmd_t     cmd
);

    mck_pkg::state_t state_reg;
    mck_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mck_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        cmd.load    = 1'b0;
        cmd.emit    = 1'b0;
        cmd.kind    = mck_pkg::EMIT_LETTER;
        cmd.advance = 1'b0;
        unique case (state_reg)
            mck_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (status.in_space)
                    begin
                        state_next = mck_pkg::ST_WORD;
                    end
                    else if (status.in_len_zero)
                    begin
                        state_next = mck_pkg::ST_LETTER;
                    end
                    else
                    begin
                        state_next = mck_pkg::ST_ON;
                    end
                end
            end
            mck_pkg::ST_WORD:
            begin
                cmd.kind = mck_pkg::EMIT_WORD;
                cmd.emit = status.out_free;
                if (status.out_free)
                begin
                    state_next = mck_pkg::ST_LETTER;
                end
            end
            mck_pkg::ST_ON:
            begin
                cmd.kind = mck_pkg::EMIT_ON;
                cmd.emit = status.out_free;
                if (status.out_free)
                begin
                    state_next = mck_pkg::ST_GAP;
                end
            end
            mck_pkg::ST_GAP:
            begin
                cmd.kind    = mck_pkg::EMIT_GAP;
                cmd.emit    = status.out_free;
                cmd.advance = status.out_free;
                if (status.out_free)
                begin
                    state_next = status.last_symbol ? mck_pkg::ST_LETTER
                                                    : mck_pkg::ST_ON;
                end
            end
            mck_pkg::ST_LETTER:
            begin
                cmd.kind = mck_pkg::EMIT_LETTER;
                cmd.emit = status.out_free;
                if (status.out_free)
                begin
                    state_next = mck_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mck_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mck_datapath.sv =====
// ----------------------------------------------------------------------------
// Morse keyer datapath
// Holds the timing registers, the symbol pattern of the current character
// and the output register that carries one interval to the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module mck_datapath
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire [mck_pkg::CharW-1:0]     character,
    input  mck_pkg::ctrl_cmd_t           cmd,
    output mck_pkg::ctrl_status_t        status,
    mck_cfg_if.sink                      cfg,
    mck_result_if.source                 results
);

    logic [mck_pkg::DurW-1:0]    dot_on_reg;
    logic [mck_pkg::DurW-1:0]    dash_on_reg;
    logic [mck_pkg::DurW-1:0]    symbol_gap_reg;
    logic [mck_pkg::DurW-1:0]    letter_gap_reg;
    logic [mck_pkg::DurW-1:0]    word_gap_reg;

    logic [mck_pkg::MaxSyms-1:0] pattern_reg;
    logic [mck_pkg::SymLenW-1:0] left_reg;

    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        tone_reg;
    logic [mck_pkg::DurW-1:0]    dur_reg;
    logic                        last_reg;
    logic                        tone_next;
    logic [mck_pkg::DurW-1:0]    dur_next;
    logic                        last_next;

    mck_pkg::morse_code_t        code;

    // Register writes are always taken; unknown indexes are dropped.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_on_reg     <= mck_pkg::DotOnReset;
            dash_on_reg    <= mck_pkg::DashOnReset;
            symbol_gap_reg <= mck_pkg::SymbolGapReset;
            letter_gap_reg <= mck_pkg::LetterGapReset;
            word_gap_reg   <= mck_pkg::WordGapReset;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                mck_pkg::CFG_DOT_ON:     dot_on_reg     <= cfg.data;
                mck_pkg::CFG_DASH_ON:    dash_on_reg    <= cfg.data;
                mck_pkg::CFG_SYMBOL_GAP: symbol_gap_reg <= cfg.data;
                mck_pkg::CFG_LETTER_GAP: letter_gap_reg <= cfg.data;
                mck_pkg::CFG_WORD_GAP:   word_gap_reg   <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    // Code lookup of the incoming character.
    assign code = mck_pkg::morse_lookup(character);

    // Symbol pattern and count of symbols still to send.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
        end
        else if (cmd.load)
        begin
            left_reg <= code.len;
        end
        else if (cmd.advance)
        begin
            left_reg <= left_reg - mck_pkg::SymLenW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pattern_reg <= code.pattern;
        end
        else if (cmd.advance)
        begin
            pattern_reg <= pattern_reg >> 1;
        end
    end

    // Status for the controller.
    always_comb
    begin
        status.in_space    = (character == mck_pkg::SpaceChar);
        status.in_len_zero = (code.len == '0);
        status.last_symbol = (left_reg == mck_pkg::SymLenW'(1));
        status.no_symbols  = (left_reg == '0);
        status.out_free    = !out_valid_reg || results.ready;
    end

    // Interval selected by the controller.
    always_comb
    begin
        tone_next = 1'b0;
        last_next = 1'b0;
        dur_next  = letter_gap_reg;
        unique case (cmd.kind)
            mck_pkg::EMIT_WORD:
            begin
                dur_next = word_gap_reg;
            end
            mck_pkg::EMIT_ON:
            begin
                tone_next = 1'b1;
                dur_next  = pattern_reg[0] ? dash_on_reg : dot_on_reg;
            end
            mck_pkg::EMIT_GAP:
            begin
                dur_next = symbol_gap_reg;
            end
            mck_pkg::EMIT_LETTER:
            begin
                last_next = 1'b1;
                dur_next  = letter_gap_reg;
            end
            default:
            begin
                dur_next = letter_gap_reg;
            end
        endcase
    end

    // Output register: filled on emit, emptied when the receiver takes it.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            tone_reg <= tone_next;
            dur_reg  <= dur_next;
            last_reg <= last_next;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.tone_on     = tone_reg;
    assign results.duration_ms = dur_reg;
    assign results.last_of_run = last_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/morse_character_keyer.sv =====
// ----------------------------------------------------------------------------
// Morse character keyer
// Turns ASCII characters into a run of timed tone-on and tone-off intervals.
// ----------------------------------------------------------------------------
// Usage:
// Each item on the chars channel is one ASCII character. Lowercase letters
// and digits are sent as Morse: a tone-on interval and a symbol gap for each
// dot or dash. A space first gives a word gap. Every character ends with a
// letter gap, flagged by last_of_run; other characters give only that gap.
// The cfg channel writes the five timing registers (always ready); the user
// must write only while the keyer is idle; the keyer does not enforce this.
// Timing: a character is accepted, then its intervals leave the output register
// one per cycle while results.ready stays high; the next character is taken
// once the controller has placed the letter gap. The pace is set by the
// controller stepping one interval per cycle into the single output register
// whenever that register is free.
// Stalls: while results.ready is low the output register holds its interval
// and the controller waits; no interval is lost.
// Reset: rst_n clears the controller and output valid, and returns the
// timing registers to 50, 200, 200, 200 and 250 ms.
// ----------------------------------------------------------------------------
`default_nettype none

module morse_character_keyer
(
    input  wire           clk,
    input  wire           rst_n,
    mck_char_if.sink      chars,
    mck_result_if.source  results,
    mck_cfg_if.sink       cfg
);

    mck_pkg::ctrl_cmd_t    cmd;
    mck_pkg::ctrl_status_t status;

    // Sequencing of the intervals.
    mck_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (chars.valid),
        .in_ready (chars.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Registers, pattern and output register.
    mck_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .character (chars.character),
        .cmd       (cmd),
        .status    (status),
        .cfg       (cfg),
        .results   (results)
    );

    // A character is worked on alone: no second one right after acceptance.
    assert property (@(posedge clk) disable iff (!rst_n)
        (chars.valid && chars.ready) |=> !chars.ready)
    else $error("character accepted while the previous one is in progress");

    // The keyer returns to ready only after placing the closing letter gap.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(chars.ready) |->
            $past(cmd.emit && cmd.kind == mck_pkg::EMIT_LETTER))
    else $error("keyer became ready without closing the character");

    // A tone-on interval is only issued while symbols remain.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.kind == mck_pkg::EMIT_ON) |-> !status.no_symbols)
    else $error("tone-on interval issued with no symbol left");

endmodule

`default_nettype wire

// ===== tb/sv/morse_character_keyer_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Morse character keyer testbench
// Sends a table of boundary characters and then several phases of random
// characters under different timing settings. Every interval leaving the
// keyer is checked against the typed table rows or a software keyer that
// tracks the register writes. Both channels idle and stall at random.
// ----------------------------------------------------------------------------

module morse_character_keyer_test;

    localparam int ClockPeriod  = 10;
    localparam int ResetCycles  = 10;
    localparam int CycleLimit   = 500_000;
    localparam int DrainLimit   = 4_000;
    localparam int TailCycles   = 20;
    localparam int MaxWait      = 15;
    localparam int PhaseCount   = 5;
    localparam int PhaseItems   = 70;
    localparam int DirectedRows = 22;
    localparam int DurMax       = (1 << mck_pkg::DurW) - 1;

    // Register indexes that no register answers to.
    localparam logic [mck_pkg::CfgIdxW-1:0] CfgSpareFirst = 3'd5;
    localparam logic [mck_pkg::CfgIdxW-1:0] CfgSpareLast  = 3'd7;

    // Uppercase bounds, used to aim random characters at untranslated ones.
    localparam logic [mck_pkg::CharW-1:0] UpperAChar = 8'h41;
    localparam logic [mck_pkg::CharW-1:0] UpperZChar = 8'h5A;

    // One timed interval as it leaves the keyer.
    typedef struct packed {
        logic                     tone_on;
        logic [mck_pkg::DurW-1:0] duration_ms;
        logic                     last_of_run;
    } interval_t;

    localparam interval_t NoInterval = '0;

    // A directed row: a character and, where it is plain, its intervals.
    typedef struct packed {
        logic [mck_pkg::CharW-1:0] character;
        logic [1:0]                typed_count;
        interval_t                 first;
        interval_t                 second;
        interval_t                 third;
    } stim_row_t;

    // Rows with a typed count of zero are left to the software keyer.
    localparam stim_row_t DirectedTable [DirectedRows] = '{
        '{8'h65, 2'd3, '{1'b1, 10'd50, 1'b0}, '{1'b0, 10'd200, 1'b0},
          '{1'b0, 10'd200, 1'b1}},
        '{8'h74, 2'd3, '{1'b1, 10'd200, 1'b0}, '{1'b0, 10'd200, 1'b0},
          '{1'b0, 10'd200, 1'b1}},
        '{8'h20, 2'd2, '{1'b0, 10'd250, 1'b0}, '{1'b0, 10'd200, 1'b1}, NoInterval},
        '{8'h41, 2'd1, '{1'b0, 10'd200, 1'b1}, NoInterval, NoInterval},
        '{8'h5A, 2'd1, '{1'b0, 10'd200, 1'b1}, NoInterval, NoInterval},
        '{8'h00, 2'd1, '{1'b0, 10'd200, 1'b1}, NoInterval, NoInterval},
        '{8'hFF, 2'd1, '{1'b0, 10'd200, 1'b1}, NoInterval, NoInterval},
        '{8'h7F, 2'd1, '{1'b0, 10'd200, 1'b1}, NoInterval, NoInterval},
        '{8'h60, 2'd1, '{1'b0, 10'd200, 1'b1}, NoInterval, NoInterval},
        '{8'h7B, 2'd1, '{1'b0, 10'd200, 1'b1}, NoInterval, NoInterval},
        '{8'h2F, 2'd1, '{1'b0, 10'd200, 1'b1}, NoInterval, NoInterval},
        '{8'h3A, 2'd1, '{1'b0, 10'd200, 1'b1}, NoInterval, NoInterval},
        '{8'h1F, 2'd1, '{1'b0, 10'd200, 1'b1}, NoInterval, NoInterval},
        '{8'h21, 2'd1, '{1'b0, 10'd200, 1'b1}, NoInterval, NoInterval},
        '{8'h61, 2'd0, NoInterval, NoInterval, NoInterval},
        '{8'h7A, 2'd0, NoInterval, NoInterval, NoInterval},
        '{8'h30, 2'd0, NoInterval, NoInterval, NoInterval},
        '{8'h39, 2'd0, NoInterval, NoInterval, NoInterval},
        '{8'h35, 2'd0, NoInterval, NoInterval, NoInterval},
        '{8'h68, 2'd0, NoInterval, NoInterval, NoInterval},
        '{8'h71, 2'd0, NoInterval, NoInterval, NoInterval},
        '{8'h79, 2'd0, NoInterval, NoInterval, NoInterval}
    };

    // Morse spellings, dots and dashes in sending order.
    string morse_letters [26] = '{
        ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
        ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.",
        "...", "-", "..-", "...-", ".--", "-..-", "-.--", "--.."
    };
    string morse_digits [10] = '{
        "-----", ".----", "..---", "...--", "....-",
        ".....", "-....", "--...", "---..", "----."
    };

    logic clk;
    logic rst_n;

    mck_char_if   char_ch ();
    mck_result_if result_ch ();
    mck_cfg_if    cfg_ch ();

    // Timing registers as the keyer should hold them.
    logic [mck_pkg::DurW-1:0] keyer_timing [5];

    // Intervals still to come, oldest first.
    interval_t   pending_intervals [$];
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    bit          send_steady = 0;
    bit          take_steady = 0;

    morse_character_keyer dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (char_ch.sink),
        .results (result_ch.source),
        .cfg     (cfg_ch.sink)
    );

    // Clock.
    initial clk = 1'b0;
    always #(ClockPeriod / 2) clk = ~clk;

    // Known values on every input from the start.
    initial
    begin
        rst_n                 <= 1'b0;
        char_ch.valid         <= 1'b0;
        char_ch.character     <= '0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.index          <= '0;
        cfg_ch.data           <= '0;
        result_ch.ready       <= 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic void queue_interval(input logic tone,
                                           input logic [mck_pkg::DurW-1:0] dur,
                                           input logic last);
        interval_t iv;
        iv.tone_on     = tone;
        iv.duration_ms = dur;
        iv.last_of_run = last;
        pending_intervals.push_back(iv);
    endfunction

    // Works out the intervals that one character gives under the current timing.
    function automatic void key_character(input logic [mck_pkg::CharW-1:0] ch);
        string code;
        int    i;
        code = "";
        if (ch >= mck_pkg::LowerAChar && ch <= mck_pkg::LowerZChar)
        begin
            code = morse_letters[ch - mck_pkg::LowerAChar];
        end
        else if (ch >= mck_pkg::DigitZero && ch <= mck_pkg::DigitNine)
        begin
            code = morse_digits[ch - mck_pkg::DigitZero];
        end
        else if (ch == mck_pkg::SpaceChar)
        begin
            queue_interval(1'b0, keyer_timing[mck_pkg::CFG_WORD_GAP], 1'b0);
        end
        for (i = 0; i < code.len(); i++)
        begin
            if (code.getc(i) == "-")
                queue_interval(1'b1, keyer_timing[mck_pkg::CFG_DASH_ON], 1'b0);
            else
                queue_interval(1'b1, keyer_timing[mck_pkg::CFG_DOT_ON], 1'b0);
            queue_interval(1'b0, keyer_timing[mck_pkg::CFG_SYMBOL_GAP], 1'b0);
        end
        queue_interval(1'b0, keyer_timing[mck_pkg::CFG_LETTER_GAP], 1'b1);
    endfunction

    // Random character, weighted towards ones that are translated.
    function automatic logic [mck_pkg::CharW-1:0] pick_character();
        int unsigned r;
        r = $urandom_range(99, 0);
        if (r < 45)
            return mck_pkg::CharW'($urandom_range(mck_pkg::LowerZChar,
                                                  mck_pkg::LowerAChar));
        else if (r < 60)
            return mck_pkg::CharW'($urandom_range(mck_pkg::DigitNine,
                                                  mck_pkg::DigitZero));
        else if (r < 70)
            return mck_pkg::SpaceChar;
        else if (r < 80)
            return mck_pkg::CharW'($urandom_range(UpperZChar, UpperAChar));
        else
            return mck_pkg::CharW'($urandom_range(255, 0));
    endfunction

    // Offers one character, after a random gap unless sending steadily, and returns once it is accepted.
    task automatic send_char(input logic [mck_pkg::CharW-1:0] ch);
        int gap;
        gap = send_steady ? 0 : $urandom_range(MaxWait, 0);
        if (gap > 0)
        begin
            char_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        char_ch.valid     <= 1'b1;
        char_ch.character <= ch;
        do
            @(posedge clk);
        while (!(char_ch.valid && char_ch.ready));
    endtask

    // Stops offering characters and waits for every interval still due.
    task automatic wait_for_idle();
        if (pending_intervals.size() != 0)
        begin
            char_ch.valid <= 1'b0;
            while (pending_intervals.size() != 0)
                @(posedge clk);
        end
    endtask

    // One register write; the write channel stays valid until finish_config.
    task automatic write_reg(input logic [mck_pkg::CfgIdxW-1:0] idx,
                             input logic [mck_pkg::DurW-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!(cfg_ch.valid && cfg_ch.ready));
        if (idx <= mck_pkg::CFG_WORD_GAP)
            keyer_timing[idx] = data;
    endtask

    task automatic finish_config();
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_spare();
        write_reg(mck_pkg::CfgIdxW'($urandom_range(CfgSpareLast, CfgSpareFirst)),
                  mck_pkg::DurW'($urandom_range(DurMax, 0)));
    endtask

    // Timing for each random phase: extremes first, then random settings.
    task automatic set_phase_timing(input int phase);
        int unsigned top;
        case (phase)
            0:
            begin
                write_spare();
                write_reg(mck_pkg::CFG_DOT_ON, mck_pkg::DurW'(DurMax));
                write_reg(mck_pkg::CFG_DASH_ON, mck_pkg::DurW'(DurMax));
                write_reg(mck_pkg::CFG_SYMBOL_GAP, mck_pkg::DurW'(DurMax));
                write_reg(mck_pkg::CFG_LETTER_GAP, mck_pkg::DurW'(DurMax));
                write_reg(mck_pkg::CFG_WORD_GAP, mck_pkg::DurW'(DurMax));
            end
            1:
            begin
                write_reg(mck_pkg::CFG_WORD_GAP, '0);
                write_reg(mck_pkg::CFG_LETTER_GAP, '0);
                write_reg(mck_pkg::CFG_SYMBOL_GAP, '0);
                write_reg(mck_pkg::CFG_DASH_ON, '0);
                write_reg(mck_pkg::CFG_DOT_ON, '0);
                write_spare();
            end
            2, 3:
            begin
                top = (phase == 2) ? DurMax : 15;
                write_reg(mck_pkg::CFG_DOT_ON, mck_pkg::DurW'($urandom_range(top, 0)));
                write_spare();
                write_reg(mck_pkg::CFG_DASH_ON, mck_pkg::DurW'($urandom_range(top, 0)));
                write_reg(mck_pkg::CFG_SYMBOL_GAP,
                          mck_pkg::DurW'($urandom_range(top, 0)));
                write_spare();
                write_reg(mck_pkg::CFG_LETTER_GAP,
                          mck_pkg::DurW'($urandom_range(top, 0)));
                write_reg(mck_pkg::CFG_WORD_GAP, mck_pkg::DurW'($urandom_range(top, 0)));
            end
            default:
            begin
                // A single register changes; the rest keep their values.
                write_reg(mck_pkg::CfgIdxW'($urandom_range(mck_pkg::CFG_WORD_GAP,
                                                           mck_pkg::CFG_DOT_ON)),
                          mck_pkg::DurW'($urandom_range(DurMax, 0)));
            end
        endcase
        finish_config();
    endtask

    // Result side: a random stall before each interval, with steady stretches.
    initial
    begin : result_sink
        int stall;
        int taken;
        taken = 0;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            if (taken % 30 == 0)
                take_steady = ($urandom_range(2, 0) == 0);
            stall = take_steady ? 0 : $urandom_range(MaxWait, 0);
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(result_ch.valid && result_ch.ready));
            taken++;
        end
    end

    // Each accepted interval against the oldest one due.
    always @(posedge clk)
    begin : result_check
        interval_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_intervals.size() == 0)
            begin
                report_mismatch($sformatf("unexpected interval tone %0b dur %0d last %0b",
                    result_ch.tone_on, result_ch.duration_ms, result_ch.last_of_run));
            end
            else
            begin
                want = pending_intervals.pop_front();
                if (result_ch.tone_on !== want.tone_on)
                    report_mismatch($sformatf("tone_on %0b, expected %0b",
                        result_ch.tone_on, want.tone_on));
                if (result_ch.duration_ms !== want.duration_ms)
                    report_mismatch($sformatf("duration_ms %0d, expected %0d",
                        result_ch.duration_ms, want.duration_ms));
                if (result_ch.last_of_run !== want.last_of_run)
                    report_mismatch($sformatf("last_of_run %0b, expected %0b",
                        result_ch.last_of_run, want.last_of_run));
            end
        end
    end

    // Hard limit on the length of the run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Main sequence.
    initial
    begin : stimulus
        stim_row_t                 row;
        logic [mck_pkg::CharW-1:0] ch;
        int                        drain;

        keyer_timing[mck_pkg::CFG_DOT_ON]     = mck_pkg::DotOnReset;
        keyer_timing[mck_pkg::CFG_DASH_ON]    = mck_pkg::DashOnReset;
        keyer_timing[mck_pkg::CFG_SYMBOL_GAP] = mck_pkg::SymbolGapReset;
        keyer_timing[mck_pkg::CFG_LETTER_GAP] = mck_pkg::LetterGapReset;
        keyer_timing[mck_pkg::CFG_WORD_GAP]   = mck_pkg::WordGapReset;

        repeat (ResetCycles) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed characters under the reset timing.
        for (int r = 0; r < DirectedRows; r++)
        begin
            row = DirectedTable[r];
            send_char(row.character);
            if (row.typed_count == 0)
            begin
                key_character(row.character);
            end
            else
            begin
                pending_intervals.push_back(row.first);
                if (row.typed_count > 1)
                    pending_intervals.push_back(row.second);
                if (row.typed_count > 2)
                    pending_intervals.push_back(row.third);
            end
        end

        // Random phases, each under its own timing.
        for (int phase = 0; phase < PhaseCount; phase++)
        begin
            wait_for_idle();
            set_phase_timing(phase);
            for (int k = 0; k < PhaseItems; k++)
            begin
                if (k % 25 == 0)
                    send_steady = ($urandom_range(2, 0) == 0);
                // Now and then the sender holds off until the keyer has drained.
                if (k == 20 || $urandom_range(49, 0) == 0)
                    wait_for_idle();
                ch = pick_character();
                send_char(ch);
                key_character(ch);
            end
        end

        // Drain and settle.
        char_ch.valid <= 1'b0;
        drain = 0;
        while (pending_intervals.size() != 0 && drain < DrainLimit)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (TailCycles) @(posedge clk);
        if (pending_intervals.size() != 0)
            report_mismatch($sformatf("%0d intervals never arrived",
                pending_intervals.size()));

        if (error_count == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/mck_pkg.sv
hw/rtl/mck_if.sv
hw/rtl/mck_ctrl.sv
hw/rtl/mck_datapath.sv
hw/rtl/morse_character_keyer.sv
tb/sv/morse_character_keyer_test.sv
